@@ hw/rtl/integer_to_ascii_formatter_core_assert.svh @@
// Assertion macros for the formatter RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_ASSERT_SVH

// Same-cycle implication.
`define I2A_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("formatter assertion failed");

// Next-cycle implication.
`define I2A_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("formatter assertion failed");

`endif

@@ hw/rtl/i2a_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package i2a_pkg;

    // Field widths of the request and character channels.
    localparam int VALUE_W  = 64;
    localparam int TYPE_W   = 3;
    localparam int FLAGS_W  = 5;
    localparam int FWIDTH_W = 7;
    localparam int CHAR_W   = 8;

    // Flag bit positions.
    localparam int FLG_LEFT  = 0;
    localparam int FLG_PLUS  = 1;
    localparam int FLG_SPACE = 2;
    localparam int FLG_ZERO  = 3;
    localparam int FLG_ALT   = 4;

    // Binary to BCD conversion: bits consumed per cycle and cycle count.
    localparam int DD_BITS     = 2;
    localparam int CONV_CYCLES = VALUE_W / DD_BITS;
    localparam int CONV_CNT_W  = $clog2(CONV_CYCLES + 1);

    // Digit counts of the power-of-two radixes.
    localparam int OCT_DIGITS = (VALUE_W + 2) / 3;
    localparam int HEX_DIGITS = VALUE_W / 4;

    // ASCII codes.
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;

    // Conversion types.
    typedef enum logic [TYPE_W-1:0] {
        CT_SDEC = 3'd0,
        CT_UDEC = 3'd1,
        CT_OCT  = 3'd2,
        CT_HEXL = 3'd3,
        CT_HEXU = 3'd4
    } conv_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic conv_step;
        logic scan_dec;
        logic setup;
        logic rd_emit;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_dec;
        logic conv_done;
        logic scan_hit;
        logic out_free;
        logic emit_last;
    } status_t;

    // ASCII character of one digit.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'd0, d};
        end else if (upper) begin
            c = CH_UPPER_A + {4'd0, d - 4'd10};
        end else begin
            c = CH_LOWER_A + {4'd0, d - 4'd10};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/i2a_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface i2a_req_if;
    import i2a_pkg::*;

    logic                valid;
    logic                ready;
    logic [TYPE_W-1:0]   req_type;
    logic [VALUE_W-1:0]  value;
    logic [FLAGS_W-1:0]  flags;
    logic [FWIDTH_W-1:0] width;

    modport source (output valid, req_type, value, flags, width, input ready);
    modport sink   (input valid, req_type, value, flags, width, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/i2a_chr_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface i2a_chr_if;
    import i2a_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_out;
    logic              last;

    modport source (output valid, char_out, last, input ready);
    modport sink   (input valid, char_out, last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/i2a_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_ascii_formatter_core_assert.svh"

module i2a_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  i2a_pkg::status_t st,
    output i2a_pkg::cmd_t   cmd
);
    import i2a_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                // Only decimal needs the BCD conversion pass.
                if (st.is_dec && !st.conv_done)
                begin
                    cmd.conv_step = 1'b1;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Walk down from the top digit to the first nonzero one.
                if (st.scan_hit)
                begin
                    cmd.setup  = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.scan_dec = 1'b1;
                end
            end
            ST_EMIT:
            begin
                cmd.rd_emit = 1'b1;
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (st.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Checks on the sequencing.
    `I2A_ASSERT_IMP(a_conv_only_dec, cmd.conv_step, st.is_dec)
    `I2A_ASSERT_NXT(a_last_to_idle, cmd.emit && st.emit_last, state_reg == ST_IDLE)
    `I2A_ASSERT_NXT(a_setup_to_emit, cmd.setup, state_reg == ST_EMIT)
    `I2A_ASSERT_IMP(a_emit_needs_room, cmd.emit, st.out_free && !in_ready)

endmodule

`default_nettype wire

@@ hw/rtl/i2a_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module i2a_dpath #(
    parameter int MAX_WIDTH   = 64,
    parameter int DIGIT_SLOTS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  i2a_pkg::cmd_t                 cmd,
    output i2a_pkg::status_t              st,
    input  logic [i2a_pkg::TYPE_W-1:0]    req_type,
    input  logic [i2a_pkg::VALUE_W-1:0]   value,
    input  logic [i2a_pkg::FLAGS_W-1:0]   flags,
    input  logic [i2a_pkg::FWIDTH_W-1:0]  width,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [i2a_pkg::CHAR_W-1:0]    char_out,
    output logic                          last
);
    import i2a_pkg::*;

    localparam int IDX_W = $clog2(DIGIT_SLOTS);
    localparam int POS_W = $clog2(MAX_WIDTH + 1);

    // Item registers.
    logic [VALUE_W-1:0]    bin_reg;
    logic [3:0]            dig_reg [DIGIT_SLOTS];
    logic [CONV_CNT_W-1:0] conv_cnt_reg;
    logic [IDX_W-1:0]      len_idx_reg;
    logic                  dec_reg;
    logic                  upper_reg;
    logic                  left_reg;
    logic                  zero_reg;
    logic [CHAR_W-1:0]     pre0_reg;
    logic [CHAR_W-1:0]     pre1_reg;
    logic [1:0]            prelen_reg;
    logic [POS_W-1:0]      width_sat_reg;
    logic [POS_W-1:0]      pad_reg;
    logic [POS_W-1:0]      flen_reg;
    logic [POS_W-1:0]      dtop_reg;
    logic [POS_W-1:0]      pz_end_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [CHAR_W-1:0]     out_char_reg;
    logic                  out_last_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    // Load-time decode.
    conv_t                 ct;
    logic                  neg;
    logic [VALUE_W-1:0]    mag;
    logic [VALUE_W+1:0]    ext;
    logic                  nz;
    logic                  left_f;
    logic [CHAR_W-1:0]     pre0_ld;
    logic [CHAR_W-1:0]     pre1_ld;
    logic [1:0]            prelen_ld;
    logic [3:0]            ld_dig [DIGIT_SLOTS];

    // Conversion step.
    logic [VALUE_W-1:0]    dd_bin;
    logic [3:0]            dd_dig [DIGIT_SLOTS];

    // Field layout and character select.
    logic [POS_W-1:0]      len_w;
    logic [POS_W-1:0]      total_w;
    logic [POS_W-1:0]      pad_w;
    logic [POS_W-1:0]      flen_w;
    logic [POS_W-1:0]      dtop_w;
    logic [IDX_W-1:0]      rd_idx;
    logic [3:0]            rd_dig;
    logic                  pre_sel;
    logic [CHAR_W-1:0]     pre_char;
    logic [CHAR_W-1:0]     sel_char;
    logic                  emit_last;

    // Decode of the request.
    assign ct     = (req_type > CT_HEXU) ? CT_UDEC : conv_t'(req_type);
    assign neg    = (ct == CT_SDEC) && value[VALUE_W-1];
    assign mag    = neg ? (VALUE_W'(0) - value) : value;
    assign ext    = {2'b00, mag};
    assign nz     = (value != '0);
    assign left_f = flags[FLG_LEFT];

    // Sign or radix prefix.
    always_comb
    begin
        pre0_ld   = CH_ZERO;
        pre1_ld   = CH_LOWER_X;
        prelen_ld = 2'd0;
        case (ct)
            CT_SDEC:
            begin
                if (neg)
                begin
                    pre0_ld   = CH_MINUS;
                    prelen_ld = 2'd1;
                end
                else if (flags[FLG_PLUS])
                begin
                    pre0_ld   = CH_PLUS;
                    prelen_ld = 2'd1;
                end
                else if (flags[FLG_SPACE])
                begin
                    pre0_ld   = CH_SPACE;
                    prelen_ld = 2'd1;
                end
            end
            CT_OCT:
            begin
                if (flags[FLG_ALT] && nz)
                begin
                    prelen_ld = 2'd1;
                end
            end
            CT_HEXL, CT_HEXU:
            begin
                if (ct == CT_HEXU)
                begin
                    pre1_ld = CH_UPPER_X;
                end
                if (flags[FLG_ALT] && nz)
                begin
                    prelen_ld = 2'd2;
                end
            end
            default:
            begin
                prelen_ld = 2'd0;
            end
        endcase
    end

    // Octal and hex digits are bit slices; decimal digits start cleared.
    for (genvar gi = 0; gi < DIGIT_SLOTS; gi++)
    begin : g_ld
        logic [3:0] oct_d;
        logic [3:0] hex_d;
        if (gi < OCT_DIGITS)
        begin : g_oct
            assign oct_d = {1'b0, ext[3*gi +: 3]};
        end
        else
        begin : g_oct_none
            assign oct_d = 4'd0;
        end
        if (gi < HEX_DIGITS)
        begin : g_hex
            assign hex_d = mag[4*gi +: 4];
        end
        else
        begin : g_hex_none
            assign hex_d = 4'd0;
        end
        assign ld_dig[gi] = (ct == CT_OCT) ? oct_d :
                            ((ct == CT_HEXL) || (ct == CT_HEXU)) ? hex_d : 4'd0;
    end

    // Shift-and-add-3 conversion, DD_BITS binary bits per cycle.
    always_comb
    begin
        dd_bin = bin_reg;
        dd_dig = dig_reg;
        for (int s = 0; s < DD_BITS; s++)
        begin
            for (int i = 0; i < DIGIT_SLOTS; i++)
            begin
                if (dd_dig[i] >= 4'd5)
                begin
                    dd_dig[i] = dd_dig[i] + 4'd3;
                end
            end
            for (int i = DIGIT_SLOTS - 1; i > 0; i--)
            begin
                dd_dig[i] = {dd_dig[i][2:0], dd_dig[i-1][3]};
            end
            dd_dig[0] = {dd_dig[0][2:0], dd_bin[VALUE_W-1]};
            dd_bin    = {dd_bin[VALUE_W-2:0], 1'b0};
        end
    end

    // One shared read port on the digit register.
    assign rd_idx = cmd.rd_emit ? IDX_W'(dtop_reg - pos_reg) : len_idx_reg;
    assign rd_dig = dig_reg[rd_idx];

    // Field layout once the digit count is known.
    assign len_w   = POS_W'(len_idx_reg) + POS_W'(1);
    assign total_w = len_w + POS_W'(prelen_reg);
    assign pad_w   = (width_sat_reg > total_w) ? (width_sat_reg - total_w) : '0;
    assign flen_w  = (width_sat_reg > total_w) ? width_sat_reg : total_w;
    assign dtop_w  = (left_reg ? total_w : flen_w) - POS_W'(1);

    // Character at the current field position.
    always_comb
    begin
        pre_sel = (left_reg || zero_reg) ? pos_reg[0] : (pos_reg - pad_reg) >= POS_W'(1);
        pre_char = pre_sel ? pre1_reg : pre0_reg;
        sel_char = digit_char(rd_dig, upper_reg);
        if (left_reg)
        begin
            if (pos_reg < POS_W'(prelen_reg))
            begin
                sel_char = pre_char;
            end
            else if (pos_reg > dtop_reg)
            begin
                sel_char = CH_SPACE;
            end
        end
        else if (zero_reg)
        begin
            if (pos_reg < POS_W'(prelen_reg))
            begin
                sel_char = pre_char;
            end
            else if (pos_reg < pz_end_reg)
            begin
                sel_char = CH_ZERO;
            end
        end
        else
        begin
            if (pos_reg < pad_reg)
            begin
                sel_char = CH_SPACE;
            end
            else if (pos_reg < pz_end_reg)
            begin
                sel_char = pre_char;
            end
        end
    end

    assign emit_last = (pos_reg == (flen_reg - POS_W'(1)));

    // Item registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg       <= mag;
            dig_reg       <= ld_dig;
            conv_cnt_reg  <= '0;
            len_idx_reg   <= IDX_W'(DIGIT_SLOTS - 1);
            dec_reg       <= (ct == CT_SDEC) || (ct == CT_UDEC);
            upper_reg     <= (ct == CT_HEXU);
            left_reg      <= left_f;
            zero_reg      <= flags[FLG_ZERO] && !left_f;
            pre0_reg      <= pre0_ld;
            pre1_reg      <= pre1_ld;
            prelen_reg    <= prelen_ld;
            width_sat_reg <= (width > FWIDTH_W'(MAX_WIDTH)) ? POS_W'(MAX_WIDTH) : POS_W'(width);
        end
        if (cmd.conv_step)
        begin
            bin_reg      <= dd_bin;
            dig_reg      <= dd_dig;
            conv_cnt_reg <= conv_cnt_reg + CONV_CNT_W'(1);
        end
        if (cmd.scan_dec)
        begin
            len_idx_reg <= len_idx_reg - IDX_W'(1);
        end
        if (cmd.setup)
        begin
            pad_reg    <= pad_w;
            flen_reg   <= flen_w;
            dtop_reg   <= dtop_w;
            pz_end_reg <= POS_W'(prelen_reg) + pad_w;
            pos_reg    <= '0;
        end
        if (cmd.emit)
        begin
            out_char_reg <= sel_char;
            out_last_reg <= emit_last;
            pos_reg      <= pos_reg + POS_W'(1);
        end
    end

    // Output register valid: set by a new character, cleared by a transfer.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Status and outputs.
    assign st.is_dec    = dec_reg;
    assign st.conv_done = (conv_cnt_reg == CONV_CNT_W'(CONV_CYCLES));
    assign st.scan_hit  = (rd_dig != 4'd0) || (len_idx_reg == '0);
    assign st.out_free  = !out_valid_reg || out_ready;
    assign st.emit_last = emit_last;

    assign out_valid = out_valid_reg;
    assign char_out  = out_char_reg;
    assign last      = out_last_reg;

endmodule

`default_nettype wire

@@ hw/rtl/integer_to_ascii_formatter_core.sv @@
// Sequence: the request is loaded, then decimal types run the BCD conversion (other types skip
// it), then the digits are scanned down to the first nonzero one, then the characters enter the output register.
// Throughput: one character per cycle while the sink is ready; the next request is taken
// in the cycle after the last character enters the output register.
// Reset: rst_n is asynchronous, active low; it idles the controller and empties the output.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_formatter_core #(
    parameter int MAX_WIDTH   = 64,
    parameter int DIGIT_SLOTS = 24
) (
    input  logic      clk,
    input  logic      rst_n,
    i2a_req_if.sink   req,
    i2a_chr_if.source txt
);
    import i2a_pkg::*;

    cmd_t    cmd;
    status_t st;

    // Sequencer.
    i2a_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .st       (st),
        .cmd      (cmd)
    );

    // Conversion and field assembly.
    i2a_dpath #(
        .MAX_WIDTH   (MAX_WIDTH),
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .req_type  (req.req_type),
        .value     (req.value),
        .flags     (req.flags),
        .width     (req.width),
        .out_valid (txt.valid),
        .out_ready (txt.ready),
        .char_out  (txt.char_out),
        .last      (txt.last)
    );

endmodule

`default_nettype wire

@@ tb/sv/integer_to_ascii_formatter_core_tb.sv @@
`timescale 1ns / 1ps

module integer_to_ascii_formatter_core_tb;
    import i2a_pkg::*;

    localparam int MAX_W       = 64;
    localparam int DIGIT_SLOTS = 24;

    // Flag masks built from the package bit positions.
    localparam logic [FLAGS_W-1:0] F_LEFT  = FLAGS_W'(1 << FLG_LEFT);
    localparam logic [FLAGS_W-1:0] F_PLUS  = FLAGS_W'(1 << FLG_PLUS);
    localparam logic [FLAGS_W-1:0] F_SPACE = FLAGS_W'(1 << FLG_SPACE);
    localparam logic [FLAGS_W-1:0] F_ZERO  = FLAGS_W'(1 << FLG_ZERO);
    localparam logic [FLAGS_W-1:0] F_ALT   = FLAGS_W'(1 << FLG_ALT);

    typedef struct packed {
        logic [TYPE_W-1:0]   req_type;
        logic [VALUE_W-1:0]  value;
        logic [FLAGS_W-1:0]  flags;
        logic [FWIDTH_W-1:0] width;
    } fmt_req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } fmt_char_t;

    logic clk;
    logic rst_n;

    i2a_req_if req_bus();
    i2a_chr_if txt_bus();

    integer_to_ascii_formatter_core #(
        .MAX_WIDTH   (MAX_W),
        .DIGIT_SLOTS (DIGIT_SLOTS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .txt   (txt_bus)
    );

    fmt_req_t  pending_reqs[$];
    fmt_char_t field_chars[$];
    fmt_req_t  next_req;

    int  gap_cnt;
    int  stall_cnt;
    int  stall_draw;
    int  errors;
    int  n_items;
    int  n_chars;
    int  n_fields_done;
    bit  calm;

    // Clock with a 10 ns period.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Wait drawn per transfer; zero throughout a calm stretch.
    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    // Expected characters of one printf-style integer conversion.
    function automatic void format_field(input fmt_req_t r);
        string             lower_tab;
        string             upper_tab;
        conv_t             ct;
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] base;
        logic              left;
        logic              zpad;
        logic              upper;
        logic [CHAR_W-1:0] prefix[$];
        logic [CHAR_W-1:0] digits[$];
        logic [CHAR_W-1:0] line[$];
        int                fw;
        int                total;
        int                pad;
        fmt_char_t         fc;
        lower_tab = "0123456789abcdef";
        upper_tab = "0123456789ABCDEF";
        ct    = (r.req_type > CT_HEXU) ? CT_UDEC : conv_t'(r.req_type);
        v     = r.value;
        left  = r.flags[FLG_LEFT];
        zpad  = r.flags[FLG_ZERO] && !left;
        upper = (ct == CT_HEXU);
        base  = 64'd10;

        // Sign or radix prefix.
        if (ct == CT_SDEC) begin
            if (v[VALUE_W-1]) begin
                prefix.push_back(CH_MINUS);
                v = -v;
            end else if (r.flags[FLG_PLUS]) begin
                prefix.push_back(CH_PLUS);
            end else if (r.flags[FLG_SPACE]) begin
                prefix.push_back(CH_SPACE);
            end
        end else if (ct == CT_OCT) begin
            base = 64'd8;
            if (r.flags[FLG_ALT] && v != 0)
                prefix.push_back(CH_ZERO);
        end else if (ct == CT_HEXL || ct == CT_HEXU) begin
            base = 64'd16;
            if (r.flags[FLG_ALT] && v != 0) begin
                prefix.push_back(CH_ZERO);
                prefix.push_back(upper ? CH_UPPER_X : CH_LOWER_X);
            end
        end

        // Digits, least significant first; pushed to the front to reverse them.
        do begin
            digits.push_front(upper ? upper_tab[v % base] : lower_tab[v % base]);
            v = v / base;
        end while (v != 0 && digits.size() < DIGIT_SLOTS);

        fw    = (r.width > MAX_W) ? MAX_W : int'(r.width);
        total = prefix.size() + digits.size();
        pad   = (fw > total) ? fw - total : 0;

        if (!left && !zpad)
            repeat (pad) line.push_back(CH_SPACE);
        foreach (prefix[i]) line.push_back(prefix[i]);
        if (zpad)
            repeat (pad) line.push_back(CH_ZERO);
        foreach (digits[i]) line.push_back(digits[i]);
        if (left)
            repeat (pad) line.push_back(CH_SPACE);
        while (line.size() > MAX_W)
            void'(line.pop_back());

        foreach (line[i]) begin
            fc.ch   = line[i];
            fc.last = (i == line.size() - 1);
            field_chars.push_back(fc);
        end
    endfunction

    // Request driver: one transfer per pending item, random gap after each.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_bus.valid    <= 1'b0;
            req_bus.req_type <= '0;
            req_bus.value    <= '0;
            req_bus.flags    <= '0;
            req_bus.width    <= '0;
            gap_cnt          <= 0;
        end else if (!req_bus.valid || req_bus.ready) begin
            if (req_bus.valid) begin
                format_field('{req_bus.req_type, req_bus.value, req_bus.flags,
                               req_bus.width});
                n_items++;
            end
            if (gap_cnt != 0) begin
                req_bus.valid <= 1'b0;
                gap_cnt       <= gap_cnt - 1;
            end else if (pending_reqs.size() != 0) begin
                next_req = pending_reqs.pop_front();
                req_bus.req_type <= next_req.req_type;
                req_bus.value    <= next_req.value;
                req_bus.flags    <= next_req.flags;
                req_bus.width    <= next_req.width;
                req_bus.valid    <= 1'b1;
                gap_cnt          <= draw_wait();
            end else begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    // Character monitor: checks each transfer and stalls ready at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            txt_bus.ready <= 1'b0;
            stall_cnt     <= 0;
        end else if (txt_bus.valid && txt_bus.ready) begin
            n_chars++;
            if (field_chars.size() == 0) begin
                if (errors < 10)
                    $display("ERROR: unexpected character %h last %b",
                             txt_bus.char_out, txt_bus.last);
                errors++;
            end else begin
                if (txt_bus.char_out !== field_chars[0].ch ||
                    txt_bus.last !== field_chars[0].last) begin
                    if (errors < 10)
                        $display("ERROR: char %0d expected %h last %b, got %h last %b",
                                 n_chars, field_chars[0].ch, field_chars[0].last,
                                 txt_bus.char_out, txt_bus.last);
                    errors++;
                end
                if (field_chars[0].last)
                    n_fields_done++;
                void'(field_chars.pop_front());
            end
            stall_draw = draw_wait();
            if (stall_draw == 0) begin
                txt_bus.ready <= 1'b1;
            end else begin
                txt_bus.ready <= 1'b0;
                stall_cnt     <= stall_draw - 1;
            end
        end else if (!txt_bus.ready) begin
            if (stall_cnt == 0)
                txt_bus.ready <= 1'b1;
            else
                stall_cnt <= stall_cnt - 1;
        end
    end

    function automatic void add_req(input logic [TYPE_W-1:0] t, input logic [VALUE_W-1:0] v,
                                    input logic [FLAGS_W-1:0] f,
                                    input logic [FWIDTH_W-1:0] w);
        pending_reqs.push_back('{t, v, f, w});
    endfunction

    // Operand mix: full range, shifted full range, small, zero, and the unsigned and signed boundaries.
    function automatic logic [VALUE_W-1:0] rand_value();
        logic [VALUE_W-1:0] full;
        full = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return full;
            1: return VALUE_W'($urandom_range(0, 1000));
            2: return '0;
            3: return ~VALUE_W'($urandom_range(0, 20));
            4: return $urandom_range(0, 1) ? {1'b1, 63'd0} + $urandom_range(0, 20)
                                            : {1'b0, {63{1'b1}}} - $urandom_range(0, 20);
            default: return full >> $urandom_range(0, 63);
        endcase
    endfunction

    function automatic void add_random(input int count);
        logic [TYPE_W-1:0]   t;
        logic [FWIDTH_W-1:0] w;
        int                  sel;
        repeat (count) begin
            t   = ($urandom_range(0, 9) == 0) ? TYPE_W'($urandom_range(5, 7))
                                               : TYPE_W'($urandom_range(0, 4));
            sel = $urandom_range(0, 9);
            if (sel < 7)
                w = FWIDTH_W'($urandom_range(0, 30));
            else if (sel < 9)
                w = FWIDTH_W'($urandom_range(31, 64));
            else
                w = FWIDTH_W'($urandom_range(65, 127));
            add_req(t, rand_value(), FLAGS_W'($urandom_range(0, 31)), w);
        end
    endfunction

    // Waits until every pushed item is accepted and every character has arrived.
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_bus.valid || field_chars.size() != 0) begin
            @(posedge clk);
            #1;
        end
    endtask

    initial
    begin
        req_bus.valid    = 1'b0;
        req_bus.req_type = '0;
        req_bus.value    = '0;
        req_bus.flags    = '0;
        req_bus.width    = '0;
        txt_bus.ready    = 1'b0;
        rst_n            = 1'b0;
        errors           = 0;
        n_items          = 0;
        n_chars          = 0;
        n_fields_done    = 0;
        calm             = 1'b0;
        repeat (12) @(posedge clk);
        #1 rst_n = 1'b1;

        // Directed: extremes, every type, and the documented corner cases.
        add_req(CT_SDEC, 64'd0, 5'd0, 7'd0);
        add_req(CT_SDEC, {64{1'b1}}, 5'd0, 7'd0);
        add_req(CT_SDEC, {1'b1, 63'd0}, 5'd0, 7'd0);
        add_req(CT_SDEC, {1'b0, {63{1'b1}}}, F_PLUS, 7'd0);
        add_req(CT_SDEC, 64'd42, F_SPACE, 7'd6);
        add_req(CT_SDEC, 64'd42, F_PLUS | F_SPACE, 7'd6);
        add_req(CT_SDEC, -64'sd1234, F_ZERO, 7'd30);
        add_req(CT_SDEC, 64'd7, F_LEFT | F_PLUS, 7'd10);
        add_req(CT_UDEC, {64{1'b1}}, F_ZERO, 7'd64);
        add_req(CT_UDEC, 64'd99, F_PLUS | F_SPACE | F_ALT, 7'd5);
        add_req(CT_OCT, 64'd0, F_ALT, 7'd4);
        add_req(CT_OCT, 64'd8, F_ALT | F_ZERO, 7'd10);
        add_req(CT_OCT, {64{1'b1}}, F_ALT, 7'd0);
        add_req(CT_HEXL, 64'hdead_beef, F_ALT, 7'd20);
        add_req(CT_HEXU, 64'hdead_beef, F_ALT | F_ZERO, 7'd20);
        add_req(CT_HEXL, 64'hdead_beef, F_ALT | F_LEFT, 7'd20);
        add_req(CT_HEXU, 64'd0, F_ALT | F_ZERO, 7'd3);
        add_req(CT_HEXL, {64{1'b1}}, F_ALT | F_PLUS, 7'd0);
        add_req(3'd5, 64'd123, F_PLUS, 7'd4);
        add_req(3'd6, {1'b1, 63'd0}, 5'd0, 7'd0);
        add_req(3'd7, 64'd5, F_ZERO, 7'd3);
        add_req(CT_SDEC, 64'd1, F_ZERO | F_LEFT, 7'd127);
        add_req(CT_UDEC, 64'd1, 5'd0, 7'd65);
        add_req(CT_HEXU, 64'h0123_4567_89ab_cdef, 5'd31, 7'd64);
        wait_drained();

        // Random traffic: random waits, then a calm stretch with no waits, then random waits again.
        add_random(150);
        wait_drained();
        calm = 1'b1;
        add_random(70);
        wait_drained();
        calm = 1'b0;
        add_random(150);
        wait_drained();
        repeat (150) @(posedge clk);

        $display("Ran %0d conversions over all types, flags and widths up to 127;",
                 n_items);
        $display("checked %0d characters in %0d fields, %0d mismatches.",
                 n_chars, n_fields_done, errors);
        if (errors == 0 && field_chars.size() == 0)
            $display("integer_to_ascii_formatter_core verification clean");
        else
            $display("integer_to_ascii_formatter_core verification failed");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #8_000_000;
        $display("ERROR: timeout with %0d characters still expected", field_chars.size());
        $display("integer_to_ascii_formatter_core verification failed");
        $finish;
    end

endmodule
